// ===== rtl/sbq_pkg.sv =====
`timescale 1ns / 1ps

package sbq_pkg;

    localparam int COEF_W = 32;
    localparam int DATA_W = 32;
    localparam int ADDR_W = 5;

    // register map, index = paddr[4:2]
    localparam logic [2:0] REG_B0 = 3'd0;
    localparam logic [2:0] REG_B1 = 3'd1;
    localparam logic [2:0] REG_B2 = 3'd2;
    localparam logic [2:0] REG_A1 = 3'd3;
    localparam logic [2:0] REG_A2 = 3'd4;

    // unity gain in q2.30
    localparam logic [COEF_W-1:0] B0_RESET = 32'h4000_0000;

    typedef logic signed [COEF_W-1:0] coef_t;

    typedef struct packed {
        coef_t b0;
        coef_t b1;
        coef_t b2;
        coef_t a1;
        coef_t a2;
    } coef_set_t;

endpackage

// ===== rtl/sbq_in_if.sv =====
`timescale 1ns / 1ps

interface sbq_in_if #(
    parameter int W = 24
);
    logic                valid;
    logic                ready;
    logic signed [W-1:0] left_in;
    logic signed [W-1:0] right_in;

    modport source (output valid, output left_in, output right_in, input ready);
    modport sink (input valid, input left_in, input right_in, output ready);
endinterface

// ===== rtl/sbq_out_if.sv =====
`timescale 1ns / 1ps

interface sbq_out_if #(
    parameter int W = 24
);
    logic                valid;
    logic                ready;
    logic signed [W-1:0] left_out;
    logic signed [W-1:0] right_out;

    modport source (output valid, output left_out, output right_out, input ready);
    modport sink (input valid, input left_out, input right_out, output ready);
endinterface

// ===== rtl/sbq_regs.sv =====
`timescale 1ns / 1ps

module sbq_regs (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [sbq_pkg::ADDR_W-1:0]     paddr,
    input  logic [sbq_pkg::DATA_W-1:0]     pwdata,
    output logic [sbq_pkg::DATA_W-1:0]     prdata,
    output logic                           pready,
    output sbq_pkg::coef_set_t             coefs
);

    sbq_pkg::coef_set_t coefs_reg;
    logic [2:0]         index;
    logic               wr_en;

    assign pready = 1'b1;
    assign index  = paddr[4:2];
    assign wr_en  = psel && penable && pwrite;
    assign coefs  = coefs_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coefs_reg.b0 <= sbq_pkg::B0_RESET;
            coefs_reg.b1 <= '0;
            coefs_reg.b2 <= '0;
            coefs_reg.a1 <= '0;
            coefs_reg.a2 <= '0;
        end
        else if (wr_en)
        begin
            case (index)
                sbq_pkg::REG_B0: coefs_reg.b0 <= pwdata;
                sbq_pkg::REG_B1: coefs_reg.b1 <= pwdata;
                sbq_pkg::REG_B2: coefs_reg.b2 <= pwdata;
                sbq_pkg::REG_A1: coefs_reg.a1 <= pwdata;
                sbq_pkg::REG_A2: coefs_reg.a2 <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (index)
            sbq_pkg::REG_B0: prdata = coefs_reg.b0;
            sbq_pkg::REG_B1: prdata = coefs_reg.b1;
            sbq_pkg::REG_B2: prdata = coefs_reg.b2;
            sbq_pkg::REG_A1: prdata = coefs_reg.a1;
            sbq_pkg::REG_A2: prdata = coefs_reg.a2;
            default:         prdata = '0;
        endcase
    end

endmodule

// ===== rtl/sbq_chan.sv =====
`timescale 1ns / 1ps

module sbq_chan #(
    parameter int SAMPLE_BITS    = 24,
    parameter int COEF_FRAC_BITS = 30
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          step,
    input  sbq_pkg::coef_set_t            coefs,
    input  logic signed [SAMPLE_BITS-1:0] x,
    output logic signed [SAMPLE_BITS-1:0] y
);

    localparam int PROD_W = SAMPLE_BITS + sbq_pkg::COEF_W;
    localparam int ACC_W  = PROD_W + 3;
    localparam logic signed [ACC_W-1:0] ROUND  = ACC_W'(1) <<< (COEF_FRAC_BITS - 1);
    localparam logic signed [ACC_W-1:0] HI_LIM =
        {{(ACC_W - SAMPLE_BITS + 1){1'b0}}, {(SAMPLE_BITS - 1){1'b1}}};
    localparam logic signed [ACC_W-1:0] LO_LIM = ~HI_LIM;

    logic signed [SAMPLE_BITS-1:0] x1_reg, x2_reg, y1_reg, y2_reg;
    logic signed [PROD_W-1:0]      p0, p1, p2, p3, p4;
    logic signed [ACC_W-1:0]       acc;
    logic signed [ACC_W-1:0]       shifted;

    assign p0 = coefs.b0 * x;
    assign p1 = coefs.b1 * x1_reg;
    assign p2 = coefs.b2 * x2_reg;
    assign p3 = coefs.a1 * y1_reg;
    assign p4 = coefs.a2 * y2_reg;

    assign acc = ACC_W'(p0) + ACC_W'(p1) + ACC_W'(p2) - ACC_W'(p3) - ACC_W'(p4) + ROUND;
    assign shifted = acc >>> COEF_FRAC_BITS;

    // clamp to the sample range
    always_comb
    begin
        if (shifted > HI_LIM)
            y = HI_LIM[SAMPLE_BITS-1:0];
        else if (shifted < LO_LIM)
            y = LO_LIM[SAMPLE_BITS-1:0];
        else
            y = shifted[SAMPLE_BITS-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x1_reg <= '0;
            x2_reg <= '0;
            y1_reg <= '0;
            y2_reg <= '0;
        end
        else if (step)
        begin
            x2_reg <= x1_reg;
            x1_reg <= x;
            y2_reg <= y1_reg;
            y1_reg <= y;
        end
    end

endmodule

// ===== rtl/stereo_biquad_df1_unit.sv =====
`timescale 1ns / 1ps

// stereo biquad, direct form 1, one section applied to both channels
// feed: one stereo frame per item (left_in, right_in), valid/ready
// result: one filtered frame per item (left_out, right_out), valid/ready
// coefficients b0 b1 b2 a1 a2 (signed q2.30) over the apb port at 0x00..0x10,
// written only while no item is in flight, a user rule left unchecked;
// reads return the stored value; path: input register, then result register
// throughput: one item per cycle unless result stalls, set by the loop
// from the history registers through five multipliers, the adder tree and
// the clamp back into the output history
// reset: history cleared to zero, b0 = 1.0, other coefficients zero,
// both frame registers empty
// receiver stall: the result register holds its item and one more frame is
// kept in the input register; feed.ready drops only when both are full
module stereo_biquad_df1_unit #(
    parameter int SAMPLE_BITS    = 24,
    parameter int COEF_FRAC_BITS = 30
) (
    input  logic                       clk,
    input  logic                       rst_n,
    sbq_in_if.sink                     feed,
    sbq_out_if.source                  result,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [sbq_pkg::ADDR_W-1:0] paddr,
    input  logic [sbq_pkg::DATA_W-1:0] pwdata,
    output logic [sbq_pkg::DATA_W-1:0] prdata,
    output logic                       pready
);

    sbq_pkg::coef_set_t coefs;

    // input register
    logic                          in_valid_reg, in_valid_next;
    logic signed [SAMPLE_BITS-1:0] in_left_reg, in_right_reg;
    // result register
    logic                          out_valid_reg, out_valid_next;
    logic signed [SAMPLE_BITS-1:0] out_left_reg, out_right_reg;

    logic                          take;
    logic                          advance;
    logic signed [SAMPLE_BITS-1:0] left_y, right_y;

    sbq_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .coefs   (coefs)
    );

    // the frame in the input register moves on when the result register frees
    assign advance    = in_valid_reg && (!out_valid_reg || result.ready);
    assign feed.ready = !in_valid_reg || advance;
    assign take       = feed.valid && feed.ready;

    // history advances exactly once per frame, as it enters the result register
    sbq_chan #(
        .SAMPLE_BITS    (SAMPLE_BITS),
        .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) u_left (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (advance),
        .coefs (coefs),
        .x     (in_left_reg),
        .y     (left_y)
    );

    sbq_chan #(
        .SAMPLE_BITS    (SAMPLE_BITS),
        .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) u_right (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (advance),
        .coefs (coefs),
        .x     (in_right_reg),
        .y     (right_y)
    );

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (take)
            in_valid_next = 1'b1;
        else if (advance)
            in_valid_next = 1'b0;

        out_valid_next = out_valid_reg;
        if (advance)
            out_valid_next = 1'b1;
        else if (result.ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload, no reset
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            in_left_reg  <= feed.left_in;
            in_right_reg <= feed.right_in;
        end
        if (advance)
        begin
            out_left_reg  <= left_y;
            out_right_reg <= right_y;
        end
    end

    assign result.valid     = out_valid_reg;
    assign result.left_out  = out_left_reg;
    assign result.right_out = out_right_reg;

`ifndef SYNTH
    // a frame leaving the input register always lands in the result register
    a_advance_fills: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_valid_reg)
        else $error("frame lost between input and result registers");

    // a waiting frame keeps its samples
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && !advance) |=>
            (in_valid_reg && $stable(in_left_reg) && $stable(in_right_reg)))
        else $error("input register changed while waiting");

    // an empty input register always accepts
    a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !in_valid_reg |-> feed.ready)
        else $error("feed stalled with empty input register");

    // a stalled result is never overwritten
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !result.ready) |-> !advance)
        else $error("result register overwritten during stall");
`endif

endmodule
